[rtl/spq_pkg.sv]
// spq_pkg: operation and status codes, cell commands and the cell control bundle
// for the stable priority queue. No dependencies.
package spq_pkg;

    localparam int TAG_W    = 16;
    localparam int FIELD_W  = 16;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 3;
    localparam int FUNC_W   = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT  = 2'd0,
        FN_POP     = 2'd1,
        FN_UPGRADE = 2'd2,
        FN_CLEAR   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_NOT_URGENT = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_FULL       = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2
    } cell_cmd_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        cell_cmd_t cmd;
        logic      occupied;  // cell index is below the entry count
        logic      del;       // on remove: take the right neighbor's entry
    } cell_ctrl_t;

endpackage

[rtl/spq_cell.sv]
// spq_cell: one slot of the sorted chain; holds a tag and priority and trades
// entries with its neighbors on insert and remove. Depends on spq_pkg.
module spq_cell #(
    parameter int PRIO_WIDTH = 16
) (
    input  logic                     clk,
    input  spq_pkg::cell_ctrl_t      ctrl,
    input  logic [spq_pkg::TAG_W-1:0] ins_tag,
    input  logic [PRIO_WIDTH-1:0]    ins_prio,
    input  logic [PRIO_WIDTH-1:0]    key_prio,
    input  logic [spq_pkg::TAG_W-1:0] match_tag,
    input  logic [PRIO_WIDTH-1:0]    match_prio,
    input  logic [spq_pkg::TAG_W-1:0] left_tag,
    input  logic [PRIO_WIDTH-1:0]    left_prio,
    input  logic                     left_le,
    input  logic [spq_pkg::TAG_W-1:0] right_tag,
    input  logic [PRIO_WIDTH-1:0]    right_prio,
    output logic [spq_pkg::TAG_W-1:0] tag,
    output logic [PRIO_WIDTH-1:0]    prio,
    output logic                     le,
    output logic                     match
);
    import spq_pkg::*;

    logic [TAG_W-1:0]      tag_reg, tag_next;
    logic [PRIO_WIDTH-1:0] prio_reg, prio_next;

    // le: this entry stays ahead of a new entry with key priority (ties keep order)
    assign le    = ctrl.occupied && (prio_reg <= key_prio);
    assign match = ctrl.occupied && (tag_reg == match_tag) && (prio_reg == match_prio);
    assign tag   = tag_reg;
    assign prio  = prio_reg;

    always_comb
    begin
        tag_next  = tag_reg;
        prio_next = prio_reg;
        case (ctrl.cmd)
            CMD_INSERT:
            begin
                if (!le)
                begin
                    if (left_le)
                    begin
                        tag_next  = ins_tag;
                        prio_next = ins_prio;
                    end
                    else
                    begin
                        tag_next  = left_tag;
                        prio_next = left_prio;
                    end
                end
            end
            CMD_REMOVE:
            begin
                if (ctrl.del)
                begin
                    tag_next  = right_tag;
                    prio_next = right_prio;
                end
            end
            default:
            begin
                tag_next  = tag_reg;
                prio_next = prio_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        prio_reg <= prio_next;
    end

endmodule

[rtl/stable_priority_queue.sv]
// stable_priority_queue: top level; sequencer, entry count, first-match prefix
// network and the row of spq_cell slots. Depends on spq_pkg and spq_cell.
//
//  channel | direction | signals
//  --------+-----------+----------------------------------------------------------
//  in      | to block  | in_valid, in_ready, func, tag, priority_req, new_priority
//  out     | from block| out_valid, out_ready, status, out_tag, out_priority,
//          |           | head_tag, head_priority, is_empty, count
//
// Insert, pop, clear and every rejected operation are done on acceptance; a successful
// upgrade does a remove shift through the chain, then an insert shift in state S_INS.
// The result register lets a new transfer in while it is taken the same cycle;
// while a result waits with out_ready low, no input is accepted.
// Reset empties the queue at once; slot contents need no clearing.
module stable_priority_queue #(
    parameter int DEPTH      = 64,
    parameter int PRIO_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [15:0] tag,
    input  logic [15:0] priority_req,
    input  logic [15:0] new_priority,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] out_tag,
    output logic [15:0] out_priority,
    output logic [15:0] head_tag,
    output logic [15:0] head_priority,
    output logic        is_empty,
    output logic [6:0]  count
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LVL   = $clog2(DEPTH);

    typedef enum logic {S_IDLE, S_INS} state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      occ_reg, occ_next;
    logic                  out_valid_reg, out_valid_next;
    status_t               status_reg, status_next;
    logic [FIELD_W-1:0]    out_tag_reg, out_tag_next;
    logic [FIELD_W-1:0]    out_prio_reg, out_prio_next;
    logic [TAG_W-1:0]      pend_tag_reg, pend_tag_next;
    logic [PRIO_WIDTH-1:0] pend_prio_reg, pend_prio_next;

    logic                  accept;
    func_t                 fn;
    logic [PRIO_WIDTH-1:0] p_in, p_new;
    logic [TAG_W-1:0]      ins_tag;
    logic [PRIO_WIDTH-1:0] ins_prio;
    cell_cmd_t             cmd;
    logic                  del_all;
    logic                  found;

    logic [TAG_W-1:0]      cell_tag  [DEPTH];
    logic [PRIO_WIDTH-1:0] cell_prio [DEPTH];
    logic [DEPTH-1:0]      cell_le;
    logic [DEPTH-1:0]      cell_match;
    logic [DEPTH-1:0]      pre [LVL+1];

    assign fn       = func_t'(func);
    assign p_in     = PRIO_WIDTH'(priority_req);
    assign p_new    = PRIO_WIDTH'(new_priority);
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // The insert step (S_INS) of an upgrade reinserts the held entry
    assign ins_tag  = (state_reg == S_INS) ? pend_tag_reg : tag;
    assign ins_prio = (state_reg == S_INS) ? pend_prio_reg : p_in;

    // Inclusive prefix OR of matches: pre[LVL][i] is set at and after the first match
    assign pre[0] = cell_match;
    genvar k, i;
    generate
        for (k = 0; k < LVL; k++)
        begin : g_lvl
            for (i = 0; i < DEPTH; i++)
            begin : g_bit
                if (i >= (1 << k))
                begin : g_or
                    assign pre[k+1][i] = pre[k][i] | pre[k][i-(1<<k)];
                end
                else
                begin : g_pass
                    assign pre[k+1][i] = pre[k][i];
                end
            end
        end
    endgenerate
    assign found = pre[LVL][DEPTH-1];

    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            cell_ctrl_t            ctrl;
            logic [TAG_W-1:0]      l_tag, r_tag;
            logic [PRIO_WIDTH-1:0] l_prio, r_prio;
            logic                  l_le;

            assign ctrl.cmd      = cmd;
            assign ctrl.occupied = (occ_reg > CNT_W'(i));
            assign ctrl.del      = del_all || pre[LVL][i];

            if (i == 0)
            begin : g_first
                assign l_tag  = ins_tag;
                assign l_prio = ins_prio;
                assign l_le   = 1'b1;
            end
            else
            begin : g_mid_l
                assign l_tag  = cell_tag[i-1];
                assign l_prio = cell_prio[i-1];
                assign l_le   = cell_le[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign r_tag  = cell_tag[i];
                assign r_prio = cell_prio[i];
            end
            else
            begin : g_mid_r
                assign r_tag  = cell_tag[i+1];
                assign r_prio = cell_prio[i+1];
            end

            spq_cell #(
                .PRIO_WIDTH(PRIO_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .ins_tag    (ins_tag),
                .ins_prio   (ins_prio),
                .key_prio   (ins_prio),
                .match_tag  (tag),
                .match_prio (p_in),
                .left_tag   (l_tag),
                .left_prio  (l_prio),
                .left_le    (l_le),
                .right_tag  (r_tag),
                .right_prio (r_prio),
                .tag        (cell_tag[i]),
                .prio       (cell_prio[i]),
                .le         (cell_le[i]),
                .match      (cell_match[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        out_tag_next   = out_tag_reg;
        out_prio_next  = out_prio_reg;
        pend_tag_next  = pend_tag_reg;
        pend_prio_next = pend_prio_reg;
        cmd            = CMD_HOLD;
        del_all        = 1'b0;

        if (state_reg == S_INS)
        begin
            cmd            = CMD_INSERT;
            occ_next       = occ_reg + 1'b1;
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            state_next     = S_IDLE;
        end
        else if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            out_tag_next   = '0;
            out_prio_next  = '0;
            case (fn)
                FN_INSERT:
                begin
                    if (occ_reg == CNT_W'(DEPTH))
                        status_next = ST_FULL;
                    else
                    begin
                        cmd      = CMD_INSERT;
                        occ_next = occ_reg + 1'b1;
                    end
                end
                FN_POP:
                begin
                    if (occ_reg == '0)
                        status_next = ST_EMPTY;
                    else
                    begin
                        cmd           = CMD_REMOVE;
                        del_all       = 1'b1;
                        out_tag_next  = cell_tag[0];
                        out_prio_next = FIELD_W'(cell_prio[0]);
                        occ_next      = occ_reg - 1'b1;
                    end
                end
                FN_UPGRADE:
                begin
                    if (p_in <= p_new)
                        status_next = ST_NOT_URGENT;
                    else if (!found)
                        status_next = ST_NOT_FOUND;
                    else
                    begin
                        cmd            = CMD_REMOVE;
                        occ_next       = occ_reg - 1'b1;
                        pend_tag_next  = tag;
                        pend_prio_next = p_new;
                        out_valid_next = 1'b0;
                        state_next     = S_INS;
                    end
                end
                FN_CLEAR:
                begin
                    occ_next = '0;
                end
                default:
                begin
                    occ_next = occ_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            out_tag_reg   <= '0;
            out_prio_reg  <= '0;
            pend_tag_reg  <= '0;
            pend_prio_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            out_tag_reg   <= out_tag_next;
            out_prio_reg  <= out_prio_next;
            pend_tag_reg  <= pend_tag_next;
            pend_prio_reg <= pend_prio_next;
        end
    end

    // Head is chain slot 0, count the entry count; they move on acceptance and in S_INS
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign out_tag       = out_tag_reg;
    assign out_priority  = out_prio_reg;
    assign is_empty      = (occ_reg == '0);
    assign head_tag      = is_empty ? '0 : cell_tag[0];
    assign head_priority = is_empty ? '0 : FIELD_W'(cell_prio[0]);
    assign count         = COUNT_W'(occ_reg);

    a_ins_completes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INS |=> out_valid_reg && occ_reg == $past(occ_reg) + 1'b1)
        else $error("upgrade reinsert did not complete");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg >= CNT_W'(2) |-> cell_prio[0] <= cell_prio[1])
        else $error("chain head out of order");

    a_no_accept_in_ins: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INS |-> !accept && !out_valid_reg)
        else $error("transfer taken during upgrade reinsert");

endmodule
